/* rtl/butd_pkg.sv */
// shared constants and types for the upwind transport derivative block
package butd_pkg;

	// default widths
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// cells in the sliding window
	localparam int WIN_DEPTH = 5;

	// requests queued between front and back, power of two
	localparam int FIFO_DEPTH = 2;

	// back end sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M1,
		ST_M2,
		ST_D2,
		ST_M3,
		ST_M4,
		ST_DV,
		ST_MX,
		ST_DX,
		ST_FACE,
		ST_MF1,
		ST_MF2,
		ST_DF,
		ST_OUT
	} back_state_t;

	// handshake of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

/* rtl/butd_front.sv */
// front end: cell window shift, fill tracking and window snapshot push
module butd_front #(
	parameter int W = butd_pkg::DATA_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic [W-1:0]                           quantity_sample,
	input  logic [W-1:0]                           velocity_sample,
	input  logic [W-1:0]                           cell_spacing,
	input  logic                                   line_start,
	output logic                                   snap_push,
	input  logic                                   snap_full,
	output logic [3*butd_pkg::WIN_DEPTH*W-1:0]     snap_data
);

	localparam int D  = butd_pkg::WIN_DEPTH;
	localparam int FW = $clog2(D + 1);

	logic [D-1:0][W-1:0] qw_q, vw_q, sw_q;
	logic [D-1:0][W-1:0] qw_n, vw_n, sw_n;
	logic [FW-1:0]       fill_q, fill_base, fill_n;
	logic                accept;

	assign accept = push && !snap_full;
	assign full   = snap_full;

	// next window contents, newest cell at the top
	always_comb begin
		for (int i = 0; i < D - 1; i++) begin
			qw_n[i] = qw_q[i+1];
			vw_n[i] = vw_q[i+1];
			sw_n[i] = sw_q[i+1];
		end
		qw_n[D-1] = quantity_sample;
		vw_n[D-1] = velocity_sample;
		// zero width is taken as one lsb
		sw_n[D-1] = (cell_spacing == '0) ? W'(1) : cell_spacing;
	end

	// fill count restarts on a new line
	always_comb begin
		fill_base = line_start ? '0 : fill_q;
		fill_n    = (fill_base < FW'(D)) ? fill_base + FW'(1) : fill_base;
	end

	assign snap_push = accept && (fill_n == FW'(D));
	assign snap_data = {sw_n, vw_n, qw_n};

	// window taps
	always_ff @(posedge clk) begin
		if (accept) begin
			qw_q <= qw_n;
			vw_q <= vw_n;
			sw_q <= sw_n;
		end
	end

	// fill counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_n;
		end
	end

endmodule

/* rtl/butd_fifo.sv */
// short request queue between front and back
module butd_fifo #(
	parameter int DW = 3 * butd_pkg::WIN_DEPTH * butd_pkg::DATA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [DW-1:0] wr_data,
	output logic          full,
	input  logic          rd_en,
	output logic [DW-1:0] rd_data,
	output logic          empty
);

	localparam int DEPTH = butd_pkg::FIFO_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	logic [DW-1:0] slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr, do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (AW+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (AW+1)'(1);
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("request queue count out of range");

endmodule

/* rtl/butd_mul.sv */
// serial shift-add signed multiplier, one operand bit per cycle
module butd_mul #(
	parameter int MW = butd_pkg::DATA_WIDTH_DEF + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [MW-1:0]   a,
	input  logic signed [MW-1:0]   b,
	output butd_pkg::unit_stat_t   stat,
	output logic signed [2*MW-1:0] p
);

	localparam int CW = $clog2(MW);

	logic [MW-1:0]   am, bm, mcand_q;
	logic [2*MW-1:0] prod_q;
	logic [MW:0]     sum;
	logic [CW-1:0]   cnt_q;
	logic            neg_q, busy_q, done_q;

	// operand magnitudes
	assign am = a[MW-1] ? MW'(-a) : MW'(a);
	assign bm = b[MW-1] ? MW'(-b) : MW'(b);

	// partial sum on the upper half
	assign sum = prod_q[0] ? {1'b0, prod_q[2*MW-1:MW]} + {1'b0, mcand_q}
	                       : {1'b0, prod_q[2*MW-1:MW]};

	assign p         = neg_q ? (2*MW)'(-prod_q) : prod_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= am;
			prod_q  <= {{MW{1'b0}}, bm};
			neg_q   <= a[MW-1] ^ b[MW-1];
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[MW-1:1]};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(MW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiplier started while busy");

endmodule

/* rtl/butd_div.sv */
// serial restoring divider, signed by unsigned, rounded half away from zero
module butd_div #(
	parameter int NW = 2 * butd_pkg::DATA_WIDTH_DEF + 4,
	parameter int DW = butd_pkg::DATA_WIDTH_DEF + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	output butd_pkg::unit_stat_t stat,
	output logic                 q_neg,
	output logic [NW-1:0]        q_mag
);

	localparam int CW = $clog2(NW);

	logic [NW-1:0] numer_q;
	logic [DW-1:0] rem_q, den_q, rem_nx;
	logic [DW:0]   rem_sh;
	logic [CW-1:0] cnt_q;
	logic          neg_q, busy_q, done_q, ge, round_up;

	// one quotient bit per cycle
	assign rem_sh = {rem_q, numer_q[NW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign rem_nx = ge ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];

	// round to nearest on the final remainder
	assign round_up  = {rem_q, 1'b0} >= {1'b0, den_q};
	assign q_mag     = numer_q + NW'(round_up);
	assign q_neg     = neg_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			numer_q <= num[NW-1] ? NW'(-num) : NW'(num);
			neg_q   <= num[NW-1];
			den_q   <= den;
			rem_q   <= '0;
		end else if (busy_q) begin
			numer_q <= {numer_q[NW-2:0], ge};
			rem_q   <= rem_nx;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");

endmodule

/* rtl/butd_back.sv */
// back end: face limiter and derivative sequencer over shared serial units
module butd_back #(
	parameter int W = butd_pkg::DATA_WIDTH_DEF,
	parameter int F = butd_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [3*butd_pkg::WIN_DEPTH*W-1:0] snap_data,
	input  logic                               snap_empty,
	output logic                               snap_pop,
	input  logic                               cfg_wr_en,
	input  logic                               cfg_wr_data,
	input  logic                               pop,
	output logic                               empty,
	output logic signed [W-1:0]                derivative_value,
	output logic                               saturated_flag
);

	localparam int D  = butd_pkg::WIN_DEPTH;
	localparam int XW = W + 2;
	localparam int PW = 2 * XW;
	localparam int NW = (PW > W + F + 2) ? PW : W + F + 2;
	localparam int DW = W + 1;
	localparam logic [NW-1:0] LIM_POS = (NW'(1) << (W - 1)) - NW'(1);
	localparam logic [NW-1:0] LIM_NEG = NW'(1) << (W - 1);

	butd_pkg::back_state_t st_q, st_n;
	butd_pkg::unit_stat_t  mul_stat, div_stat;

	logic [D-1:0][W-1:0] q_q, v_q, s_q;
	logic                face_q, issued_q, mbv_q, res_valid_q, sat_q;
	logic [W-1:0]        der_q;

	logic signed [XW-1:0] d1_q, d2_q, vf_q, vfl_q, fl_q, fr_q;
	logic signed [NW-1:0] acc_q;
	logic                 qneg_q;
	logic [NW-1:0]        qmag_q;

	logic signed [XW-1:0] ql, qr, qul, qur, vl, vr;
	logic [W-1:0]         sl, sr, sul, sur;
	logic signed [XW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [NW-1:0] p_ext, diff_sh;
	logic signed [NW-1:0] div_num;
	logic [DW-1:0]        div_den;
	logic                 div_neg;
	logic [NW-1:0]        div_mag;
	logic signed [NW:0]   qs;
	logic signed [XW-1:0] q_x, d_max, d_min, face_val, up_base;
	logic signed [XW:0]   fdiff;
	logic                 mul_state, div_state, mul_start, div_start, unit_done;
	logic                 sat_hi, sat_lo;
	logic [NW-1:0]        qmag_neg;
	logic [W-1:0]         res_val;

	// taps of the current face
	always_comb begin
		ql  = face_q ? XW'(signed'(q_q[2])) : XW'(signed'(q_q[1]));
		qr  = face_q ? XW'(signed'(q_q[3])) : XW'(signed'(q_q[2]));
		qul = face_q ? XW'(signed'(q_q[1])) : XW'(signed'(q_q[0]));
		qur = face_q ? XW'(signed'(q_q[4])) : XW'(signed'(q_q[3]));
		vl  = face_q ? XW'(signed'(v_q[2])) : XW'(signed'(v_q[1]));
		vr  = face_q ? XW'(signed'(v_q[3])) : XW'(signed'(v_q[2]));
		sl  = face_q ? s_q[2] : s_q[1];
		sr  = face_q ? s_q[3] : s_q[2];
		sul = face_q ? s_q[1] : s_q[0];
		sur = face_q ? s_q[4] : s_q[3];
	end

	// unit results in working widths
	assign p_ext   = NW'(mul_p);
	assign qs      = div_neg ? -$signed({1'b0, div_mag}) : $signed({1'b0, div_mag});
	assign q_x     = qs[XW-1:0];
	assign up_base = (vf_q > 0) ? ql : qr;
	assign fdiff   = (XW+1)'(fr_q) - (XW+1)'(fl_q);
	assign diff_sh = NW'(fdiff) <<< F;

	// barton limiter on the face
	always_comb begin
		d_max = (d1_q > d2_q) ? d1_q : d2_q;
		d_min = (d1_q < d2_q) ? d1_q : d2_q;
		if (vf_q > 0) begin
			if (qr <= ql) begin
				face_val = (ql < d_max) ? ql : d_max;
			end else begin
				face_val = (ql > d_min) ? ql : d_min;
			end
		end else if (vf_q < 0) begin
			if (qr <= ql) begin
				face_val = (qr > d_min) ? qr : d_min;
			end else begin
				face_val = (qr < d_max) ? qr : d_max;
			end
		end else begin
			face_val = d2_q;
		end
	end

	// saturation of the final quotient
	always_comb begin
		qmag_neg = -qmag_q;
		sat_hi   = !qneg_q && (qmag_q > LIM_POS);
		sat_lo   = qneg_q && (qmag_q > LIM_NEG);
		if (sat_hi) begin
			res_val = {1'b0, {(W-1){1'b1}}};
		end else if (sat_lo) begin
			res_val = {1'b1, {(W-1){1'b0}}};
		end else if (qneg_q) begin
			res_val = qmag_neg[W-1:0];
		end else begin
			res_val = qmag_q[W-1:0];
		end
	end

	// sequencer outputs and operand selection
	always_comb begin
		mul_state = 1'b0;
		div_state = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_num   = acc_q;
		div_den   = DW'(sl) + DW'(sr);
		unique case (st_q)
			butd_pkg::ST_M1: begin
				mul_state = 1'b1;
				mul_a     = ql;
				mul_b     = XW'(sr);
			end
			butd_pkg::ST_M2: begin
				mul_state = 1'b1;
				mul_a     = qr;
				mul_b     = XW'(sl);
			end
			butd_pkg::ST_M3: begin
				mul_state = 1'b1;
				mul_a     = vl;
				mul_b     = XW'(sr);
			end
			butd_pkg::ST_M4: begin
				mul_state = 1'b1;
				mul_a     = vr;
				mul_b     = XW'(sl);
			end
			butd_pkg::ST_MX: begin
				mul_state = 1'b1;
				mul_a     = (vf_q > 0) ? ql - qul : qr - qur;
				mul_b     = (vf_q > 0) ? XW'(sl) : XW'(sr);
			end
			// face values times their interpolated face velocities
			butd_pkg::ST_MF1: begin
				mul_state = mbv_q;
				mul_a     = fr_q;
				mul_b     = vf_q;
			end
			butd_pkg::ST_MF2: begin
				mul_state = 1'b1;
				mul_a     = fl_q;
				mul_b     = vfl_q;
			end
			butd_pkg::ST_D2, butd_pkg::ST_DV: begin
				div_state = 1'b1;
			end
			butd_pkg::ST_DX: begin
				div_state = 1'b1;
				div_den   = (vf_q > 0) ? DW'(sul) + DW'(sl) : DW'(sur) + DW'(sr);
			end
			butd_pkg::ST_DF: begin
				div_state = 1'b1;
				div_den   = DW'(s_q[2]);
			end
			default: begin
			end
		endcase
		mul_start = mul_state && !issued_q;
		div_start = div_state && !issued_q;
		unit_done = (mul_state && mul_stat.done) || (div_state && div_stat.done);
		snap_pop  = (st_q == butd_pkg::ST_IDLE) && !snap_empty;
	end

	// sequencer next state
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			butd_pkg::ST_IDLE: if (!snap_empty) st_n = butd_pkg::ST_M1;
			butd_pkg::ST_M1:   if (unit_done) st_n = butd_pkg::ST_M2;
			butd_pkg::ST_M2:   if (unit_done) st_n = butd_pkg::ST_D2;
			butd_pkg::ST_D2:   if (unit_done) st_n = butd_pkg::ST_M3;
			butd_pkg::ST_M3:   if (unit_done) st_n = butd_pkg::ST_M4;
			butd_pkg::ST_M4:   if (unit_done) st_n = butd_pkg::ST_DV;
			butd_pkg::ST_DV: begin
				if (unit_done) st_n = (q_x == '0) ? butd_pkg::ST_FACE : butd_pkg::ST_MX;
			end
			butd_pkg::ST_MX:   if (unit_done) st_n = butd_pkg::ST_DX;
			butd_pkg::ST_DX:   if (unit_done) st_n = butd_pkg::ST_FACE;
			butd_pkg::ST_FACE: st_n = face_q ? butd_pkg::ST_MF1 : butd_pkg::ST_M1;
			butd_pkg::ST_MF1: begin
				if (!mbv_q) begin
					st_n = butd_pkg::ST_DF;
				end else if (unit_done) begin
					st_n = butd_pkg::ST_MF2;
				end
			end
			butd_pkg::ST_MF2:  if (unit_done) st_n = butd_pkg::ST_DF;
			butd_pkg::ST_DF:   if (unit_done) st_n = butd_pkg::ST_OUT;
			butd_pkg::ST_OUT:  if (!res_valid_q) st_n = butd_pkg::ST_IDLE;
			default:           st_n = butd_pkg::ST_IDLE;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		case (st_q)
			butd_pkg::ST_IDLE: begin
				if (!snap_empty) begin
					{s_q, v_q, q_q} <= snap_data;
				end
			end
			butd_pkg::ST_M1, butd_pkg::ST_M3, butd_pkg::ST_MX: begin
				if (unit_done) acc_q <= p_ext;
			end
			butd_pkg::ST_M2, butd_pkg::ST_M4: begin
				if (unit_done) acc_q <= acc_q + p_ext;
			end
			butd_pkg::ST_D2: if (unit_done) d2_q <= q_x;
			butd_pkg::ST_DV: if (unit_done) vf_q <= q_x;
			butd_pkg::ST_DX: if (unit_done) d1_q <= up_base + q_x;
			butd_pkg::ST_FACE: begin
				if (face_q) begin
					fr_q <= face_val;
				end else begin
					fl_q  <= face_val;
					vfl_q <= vf_q;
				end
			end
			butd_pkg::ST_MF1: begin
				if (!mbv_q) begin
					acc_q <= diff_sh;
				end else if (unit_done) begin
					acc_q <= p_ext;
				end
			end
			butd_pkg::ST_MF2: if (unit_done) acc_q <= acc_q - p_ext;
			butd_pkg::ST_DF: begin
				if (unit_done) begin
					qneg_q <= div_neg;
					qmag_q <= div_mag;
				end
			end
			butd_pkg::ST_OUT: begin
				if (!res_valid_q) begin
					der_q <= res_val;
					sat_q <= sat_hi || sat_lo;
				end
			end
			default: begin
			end
		endcase
	end

	// control state, config and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= butd_pkg::ST_IDLE;
			face_q      <= 1'b0;
			issued_q    <= 1'b0;
			mbv_q       <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end else if (unit_done) begin
				issued_q <= 1'b0;
			end
			if (st_q == butd_pkg::ST_IDLE) begin
				face_q <= 1'b0;
			end else if (st_q == butd_pkg::ST_FACE) begin
				face_q <= ~face_q;
			end
			if (cfg_wr_en) begin
				mbv_q <= cfg_wr_data;
			end
			if (st_q == butd_pkg::ST_OUT && !res_valid_q) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign empty            = !res_valid_q;
	assign derivative_value = der_q;
	assign saturated_flag   = sat_q;

	// shared serial units
	butd_mul #(.MW(XW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.stat   (mul_stat),
		.p      (mul_p)
	);

	butd_div #(.NW(NW), .DW(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.q_neg  (div_neg),
		.q_mag  (div_mag)
	);

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == butd_pkg::ST_IDLE |-> !issued_q)
		else $error("unit request left open in idle");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == butd_pkg::ST_OUT && !res_valid_q) |=> res_valid_q)
		else $error("result not loaded into output register");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_start && div_start))
		else $error("both units started together");

endmodule

/* rtl/barton_upwind_transport_derivative.sv */
// top level of the upwind transport derivative block
// the divider works on NW bits, NW being the larger of 2*DATA_WIDTH+4 and
//   DATA_WIDTH+FRAC_BITS+2
// the back end works through one window at a time on the shared serial multiplier and
//   divider; cells that give no result are taken one per cycle while the queue is not full
// reset: window fill clears, multiply_by_velocity sets to 1, no result is waiting
module barton_upwind_transport_derivative #(
	parameter int DATA_WIDTH = butd_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = butd_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [DATA_WIDTH-1:0] quantity_sample,
	input  logic signed [DATA_WIDTH-1:0] velocity_sample,
	input  logic [DATA_WIDTH-1:0]        cell_spacing,
	input  logic                         line_start,
	input  logic                         cfg_wr_en,
	input  logic                         cfg_wr_data,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [DATA_WIDTH-1:0] derivative_value,
	output logic                         saturated_flag
);

	localparam int SW = 3 * butd_pkg::WIN_DEPTH * DATA_WIDTH;

	logic          snap_push, snap_full, snap_pop, snap_empty;
	logic [SW-1:0] snap_wr, snap_rd;

	// window and fill tracking
	butd_front #(.W(DATA_WIDTH)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.quantity_sample (quantity_sample),
		.velocity_sample (velocity_sample),
		.cell_spacing    (cell_spacing),
		.line_start      (line_start),
		.snap_push       (snap_push),
		.snap_full       (snap_full),
		.snap_data       (snap_wr)
	);

	// request queue
	butd_fifo #(.DW(SW)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (snap_push),
		.wr_data (snap_wr),
		.full    (snap_full),
		.rd_en   (snap_pop),
		.rd_data (snap_rd),
		.empty   (snap_empty)
	);

	// arithmetic back end
	butd_back #(.W(DATA_WIDTH), .F(FRAC_BITS)) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.snap_data        (snap_rd),
		.snap_empty       (snap_empty),
		.snap_pop         (snap_pop),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.pop              (pop),
		.empty            (empty),
		.derivative_value (derivative_value),
		.saturated_flag   (saturated_flag)
	);

endmodule

/* test/testbench.sv */
// self-checking testbench for the upwind transport derivative block
module testbench;

	localparam int DW          = 32;
	localparam int FB          = 16;
	localparam int WIN_DEPTH   = butd_pkg::WIN_DEPTH;
	localparam int LATENCY     = 12 * (DW + 4) + 7 * (2 * DW + 6);
	localparam int STALL_LIMIT = 20 * LATENCY;
	localparam int RANDOM_ITEMS = 1950;
	localparam logic [DW-1:0] ONE = 32'h0001_0000;

	typedef logic signed [127:0] wide_t;

	// kinds of directed table rows
	typedef enum logic [1:0] {
		ROW_CELL,
		ROW_MODE
	} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		logic [DW-1:0] quantity;
		logic [DW-1:0] velocity;
		logic [DW-1:0] spacing;
		logic          start;
		logic          fixed_valid;
		logic [DW-1:0] fixed_value;
		logic          fixed_sat;
	} row_t;

	typedef struct {
		logic [DW-1:0] value;
		logic          sat;
	} deriv_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic signed [DW-1:0] quantity_sample = '0;
	logic signed [DW-1:0] velocity_sample = '0;
	logic [DW-1:0]        cell_spacing = ONE;
	logic                 line_start = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic                 cfg_wr_data = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic signed [DW-1:0] derivative_value;
	logic                 saturated_flag;

	// predictor state
	wide_t  quant_win [WIN_DEPTH];
	wide_t  vel_win [WIN_DEPTH];
	wide_t  width_win [WIN_DEPTH];
	int     fill_count = 0;
	logic   flux_mode = 1'b1;
	deriv_t pending_derivs[$];
	row_t   stim_rows[$];
	int     error_count = 0;
	int     idle_cycles = 0;
	int     pop_hold = 0;

	barton_upwind_transport_derivative #(
		.DATA_WIDTH(DW),
		.FRAC_BITS(FB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.quantity_sample(quantity_sample),
		.velocity_sample(velocity_sample),
		.cell_spacing(cell_spacing),
		.line_start(line_start),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.empty(empty),
		.pop(pop),
		.derivative_value(derivative_value),
		.saturated_flag(saturated_flag)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// rounded division, ties away from zero
	function automatic wide_t round_div(wide_t n, wide_t d);
		wide_t mag;
		wide_t q;
		wide_t r;
		mag = (n < 0) ? -n : n;
		q = mag / d;
		r = mag % d;
		if (r >= d - r) q = q + 1;
		return (n < 0) ? -q : q;
	endfunction

	function automatic wide_t face_interp(wide_t a, wide_t b, wide_t sa, wide_t sb);
		return round_div(a * sb + b * sa, sa + sb);
	endfunction

	function automatic wide_t face_extrap(wide_t a, wide_t b, wide_t sa, wide_t sb);
		return b + round_div((b - a) * sb, sa + sb);
	endfunction

	function automatic wide_t wmin(wide_t a, wide_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic wide_t wmax(wide_t a, wide_t b);
		return (a > b) ? a : b;
	endfunction

	// limited face value between window cells k-1 and k
	function automatic wide_t limited_face(int k, output wide_t face_vel);
		wide_t ql;
		wide_t qr;
		wide_t mid;
		wide_t upw;
		ql = quant_win[k-1];
		qr = quant_win[k];
		mid = face_interp(ql, qr, width_win[k-1], width_win[k]);
		face_vel = face_interp(vel_win[k-1], vel_win[k], width_win[k-1], width_win[k]);
		if (face_vel > 0) begin
			upw = face_extrap(quant_win[k-2], ql, width_win[k-2], width_win[k-1]);
			return (qr <= ql) ? wmin(ql, wmax(upw, mid)) : wmax(ql, wmin(upw, mid));
		end
		if (face_vel < 0) begin
			upw = face_extrap(quant_win[k+1], qr, width_win[k+1], width_win[k]);
			return (qr <= ql) ? wmax(qr, wmin(upw, mid)) : wmin(qr, wmax(upw, mid));
		end
		return mid;
	endfunction

	// shift one cell into the window; returns 1 with a derivative when the window is full
	function automatic bit shift_cell(logic [DW-1:0] q, logic [DW-1:0] v, logic [DW-1:0] s,
			logic start, output deriv_t d);
		wide_t fl;
		wide_t fr;
		wide_t vl;
		wide_t vr;
		wide_t num;
		wide_t res;
		if (start) fill_count = 0;
		for (int i = 0; i < WIN_DEPTH - 1; i++) begin
			quant_win[i] = quant_win[i+1];
			vel_win[i] = vel_win[i+1];
			width_win[i] = width_win[i+1];
		end
		quant_win[WIN_DEPTH-1] = wide_t'($signed(q));
		vel_win[WIN_DEPTH-1] = wide_t'($signed(v));
		width_win[WIN_DEPTH-1] = (s == 0) ? wide_t'(1) : wide_t'({1'b0, s});
		if (fill_count < WIN_DEPTH) fill_count++;
		d = '{default: '0};
		if (fill_count < WIN_DEPTH) return 0;
		fl = limited_face(2, vl);
		fr = limited_face(3, vr);
		if (flux_mode) num = fr * vr - fl * vl;
		else num = (fr - fl) <<< FB;
		res = round_div(num, width_win[2]);
		if (res > wide_t'(32'sh7fff_ffff)) begin
			d.value = 32'h7fff_ffff;
			d.sat = 1'b1;
		end else if (res < -wide_t'(64'sh8000_0000)) begin
			d.value = 32'h8000_0000;
			d.sat = 1'b1;
		end else begin
			d.value = res[DW-1:0];
		end
		return 1;
	endfunction

	task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
		$display("mismatch: %s got %h expected %h", what, got, want);
		error_count++;
	endtask

	// drive one request and hold it until accepted, then an optional gap
	task automatic send_cell(logic [DW-1:0] q, logic [DW-1:0] v, logic [DW-1:0] s,
			logic start, logic fixed_valid, deriv_t fixed);
		deriv_t d;
		int r;
		push <= 1'b1;
		quantity_sample <= q;
		velocity_sample <= v;
		cell_spacing <= s;
		line_start <= start;
		do @(posedge clk); while (full);
		if (shift_cell(q, v, s, start, d))
			pending_derivs.push_back(fixed_valid ? fixed : d);
		r = $urandom_range(0, 99);
		if (r >= 60) begin
			push <= 1'b0;
			if (r < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
			else repeat ($urandom_range(10, 50)) @(posedge clk);
		end
	endtask

	// write the mode register once the block has drained
	task automatic set_mode(logic m);
		push <= 1'b0;
		while (pending_derivs.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		flux_mode = m;
	endtask

	task automatic add_row(row_kind_t k, logic [DW-1:0] q, logic [DW-1:0] v,
			logic [DW-1:0] s, logic st, logic fv, logic [DW-1:0] fx, logic fs);
		stim_rows.push_back('{k, q, v, s, st, fv, fx, fs});
	endtask

	function automatic logic [DW-1:0] rand_quantity();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) return $urandom;
		if (r < 8) return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
		return (r == 8) ? 32'h7fff_ffff : 32'h8000_0000;
	endfunction

	function automatic logic [DW-1:0] rand_velocity();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) return '0;
		if (r < 6) return $urandom;
		return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
	endfunction

	function automatic logic [DW-1:0] rand_spacing();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5) return $urandom_range(32'h0000_8000, 32'h0004_0000);
		if (r < 8) return ($urandom == 0) ? 32'h1 : $urandom;
		return (r == 8) ? 32'h1 : 32'hffff_ffff;
	endfunction

	// result side: random pops, compare with oldest expectation
	always @(posedge clk) begin
		deriv_t e;
		int r;
		if (arst_n) begin
			if (pop && !empty) begin
				if (pending_derivs.size() == 0) begin
					$display("mismatch: result with nothing expected, value %h", derivative_value);
					error_count++;
				end else begin
					e = pending_derivs.pop_front();
					if (derivative_value !== e.value)
						report_mismatch("derivative_value", derivative_value, e.value);
					if (saturated_flag !== e.sat)
						report_mismatch("saturated_flag", saturated_flag, e.sat);
				end
			end
			if (pop_hold > 0) begin
				pop_hold--;
				pop <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 3) pop_hold = $urandom_range(10, 80);
				else if (r < 25) pop_hold = $urandom_range(1, 3);
				pop <= (r >= 25);
			end
		end
	end

	// watchdog on cycles without any accepted request or popped result
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// stimulus
	initial begin
		row_t   row;
		deriv_t fixed;
		int     len;
		int     phase_len;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			quant_win[i] = '0;
			vel_win[i] = '0;
			width_win[i] = '0;
		end
		// directed: flat line after reset gives zero
		for (int i = 0; i < 6; i++)
			add_row(ROW_CELL, 32'h0005_0000, ONE, ONE, i == 0, 1'b1, '0, 1'b0);
		// extremes alternating with narrowest width saturate
		for (int i = 0; i < 6; i++)
			add_row(ROW_CELL, i[0] ? 32'h8000_0000 : 32'h7fff_ffff,
				i[1] ? 32'h8000_0000 : 32'h7fff_ffff, 32'h1, i == 0, 1'b0, '0, 1'b0);
		// zero face velocity with widest cells
		for (int i = 0; i < 6; i++)
			add_row(ROW_CELL, i * 32'h0003_0000, i[0] ? 32'hffff_0000 : ONE,
				32'hffff_ffff, i == 0, 1'b0, '0, 1'b0);
		// quantity only: linear ramp gives one step per cell
		add_row(ROW_MODE, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0);
		for (int i = 0; i < 6; i++)
			add_row(ROW_CELL, i * ONE, ONE, ONE, i == 0, 1'b1, ONE, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.kind == ROW_MODE) begin
				set_mode(1'b0);
			end else begin
				fixed.value = row.fixed_value;
				fixed.sat = row.fixed_sat;
				send_cell(row.quantity, row.velocity, row.spacing, row.start,
					row.fixed_valid, fixed);
			end
		end

		// random lines in phases of alternating mode
		fixed = '{default: '0};
		for (int p = 0; p < 4; p++) begin
			set_mode(p[0] ? 1'b0 : 1'b1);
			phase_len = 0;
			while (phase_len < RANDOM_ITEMS / 4) begin
				if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 4);
				else if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 14);
				else len = $urandom_range(5, 8);
				for (int c = 0; c < len; c++)
					send_cell(rand_quantity(), rand_velocity(), rand_spacing(),
						(c == 0) || ($urandom_range(0, 199) == 0), 1'b0, fixed);
				phase_len += len;
			end
		end

		push <= 1'b0;
		while (pending_derivs.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (error_count == 0) $display("testbench: done, clean");
		else $display("testbench: done, errors");
		$finish;
	end

endmodule
